// ----- hw/rtl/lrupr_pkg.sv -----
// Package for the LRU page replacement block: widths, types and the
// control bundle that the top level hands to each recency cell.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

    // Number of recency cells (page frames) built into the block.
    localparam int FRAMES = 16;

    // Field widths fixed by the interface.
    localparam int PAGE_W  = 20;
    localparam int FC_W    = 5;
    localparam int FAULT_W = 32;

    // Occupancy counts 0..FRAMES; an index reaches FRAMES-1.
    localparam int OCC_W = $clog2(FRAMES + 1);
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // Frame count after reset.
    localparam logic [FC_W-1:0] FC_RESET = FC_W'(16);

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [OCC_W-1:0]   occ_t;
    typedef logic [FC_W-1:0]    fc_t;
    typedef logic [FAULT_W-1:0] fault_t;

    // Per-cell control from the top level for the current cycle.
    typedef struct packed {
        logic accept;  // an item is taken this cycle
        logic hit;     // the page was found somewhere in the row
        logic valid;   // this cell lies below the occupancy
        logic fill;    // on a miss this cell lies below the new occupancy
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrupr_if.sv -----
// Channel interfaces of the LRU page replacement block: the page reference
// channel and the result channel, each with valid/ready handshake.
// Depends on lrupr_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lrupr_in_if;
    logic            valid;
    logic            ready;
    lrupr_pkg::page_t page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_out_if;
    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted_valid;
    lrupr_pkg::page_t  victim_page;
    lrupr_pkg::fault_t fault_count;

    modport source (output valid, output hit, output evicted_valid,
                    output victim_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid,
                    input victim_page, input fault_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement block: row of recency cells,
// occupancy and fault counters, frame count register and result register.
// Depends on lrupr_pkg, lrupr_if.sv and lrupr_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block tracks up to FRAMES resident pages in recency order, the most
// recent in cell 0. Each page reference item yields one result item in the
// cycle after it is taken: hit flag, evicted page (zero when none) and the
// saturating fault total. One reference is taken every cycle while the
// result side keeps up; the figure is set by the parallel compare across
// all cells followed by the ripple that locates the match and steers the
// shift. The result register lets a new item in while the previous result
// is taken in the same cycle. frame_count must be written only while the
// block is idle; the block does not enforce it. Zero acts as one, values
// above FRAMES as FRAMES; lowering it below occupancy drops nothing at once.
module lru_page_replacement_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire lrupr_pkg::fc_t cfg_wdata,
    lrupr_in_if.sink            page_ref,
    lrupr_out_if.source         outcome
);

    localparam int N = lrupr_pkg::FRAMES;

    lrupr_pkg::fc_t    frame_count_reg;
    lrupr_pkg::occ_t   occ_reg;
    lrupr_pkg::occ_t   occ_next;
    lrupr_pkg::fault_t fault_total_reg;
    lrupr_pkg::fault_t fault_total_next;
    lrupr_pkg::occ_t   limit;

    logic              out_valid_reg;
    logic              hit_reg;
    logic              evicted_valid_reg;
    lrupr_pkg::page_t  victim_page_reg;
    lrupr_pkg::fault_t fault_count_reg;

    logic              accept;
    logic              hit;
    logic              evict;
    lrupr_pkg::page_t  victim_page;
    lrupr_pkg::occ_t   last_pos;

    lrupr_pkg::page_t  entries [N];
    lrupr_pkg::page_t  lefts   [N];
    logic [N:0]        seen;
    lrupr_pkg::cell_ctrl_t ctrls [N];

    // Input is taken whenever the result register is free or being emptied.
    assign page_ref.ready = !out_valid_reg || outcome.ready;
    assign accept         = page_ref.valid && page_ref.ready;

    // Frame count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lrupr_pkg::FC_RESET;
        end
        else if (cfg_we)
        begin
            frame_count_reg <= cfg_wdata;
        end
    end

    // Effective frame limit, clamped to 1..FRAMES.
    always_comb
    begin
        priority if (frame_count_reg == '0)
        begin
            limit = lrupr_pkg::OCC_W'(1);
        end
        else if (int'(frame_count_reg) > N)
        begin
            limit = lrupr_pkg::OCC_W'(N);
        end
        else
        begin
            limit = lrupr_pkg::OCC_W'(frame_count_reg);
        end
    end

    // Row of recency cells; cell 0 takes the new page, the others take
    // their left neighbour. The seen chain finds the first match.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign lefts[i] = page_ref.page_number;
        end
        else
        begin : g_body
            assign lefts[i] = entries[i-1];
        end

        assign ctrls[i].accept = accept;
        assign ctrls[i].hit    = hit;
        assign ctrls[i].valid  = lrupr_pkg::OCC_W'(i) < occ_reg;
        assign ctrls[i].fill   = lrupr_pkg::OCC_W'(i) < occ_next;

        lrupr_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrls[i]),
            .page_number (page_ref.page_number),
            .left_page   (lefts[i]),
            .seen_in     (seen[i]),
            .entry       (entries[i]),
            .seen_out    (seen[i+1])
        );
    end

    assign hit = seen[N];

    // Miss handling: evict the least recent page when the frames are full.
    assign evict    = !hit && (occ_reg >= limit) && (occ_reg != '0);
    assign last_pos = occ_reg - lrupr_pkg::OCC_W'(1);

    always_comb
    begin
        victim_page = '0;
        if (evict)
        begin
            victim_page = entries[last_pos[lrupr_pkg::IDX_W-1:0]];
        end
    end

    always_comb
    begin
        occ_next         = occ_reg;
        fault_total_next = fault_total_reg;
        if (!hit)
        begin
            if (!evict)
            begin
                occ_next = occ_reg + lrupr_pkg::OCC_W'(1);
            end
            if (fault_total_reg != '1)
            begin
                fault_total_next = fault_total_reg + lrupr_pkg::FAULT_W'(1);
            end
        end
    end

    // Occupancy and fault counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg         <= '0;
            fault_total_reg <= '0;
        end
        else if (accept)
        begin
            occ_reg         <= occ_next;
            fault_total_reg <= fault_total_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (outcome.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg           <= hit;
            evicted_valid_reg <= evict;
            victim_page_reg   <= victim_page;
            fault_count_reg   <= fault_total_next;
        end
    end

    assign outcome.valid         = out_valid_reg;
    assign outcome.hit           = hit_reg;
    assign outcome.evicted_valid = evicted_valid_reg;
    assign outcome.victim_page   = victim_page_reg;
    assign outcome.fault_count   = fault_count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lrupr_cell.sv -----
// One recency cell: holds one resident page, compares it with the incoming
// reference and takes its left neighbour's page when the row shifts.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_cell (
    input  wire                        clk,
    input  wire lrupr_pkg::cell_ctrl_t ctrl,
    input  wire lrupr_pkg::page_t      page_number,
    input  wire lrupr_pkg::page_t      left_page,
    input  wire                        seen_in,
    output lrupr_pkg::page_t           entry,
    output logic                       seen_out
);

    lrupr_pkg::page_t entry_reg;
    lrupr_pkg::page_t entry_next;
    logic             shift;
    logic             match;

    // Only cells below the occupancy hold a resident page.
    assign match    = ctrl.valid && (entry_reg == page_number);
    assign seen_out = seen_in | match;

    // On a hit, cells up to and including the matching one shift right; on
    // a miss, every cell below the new occupancy does.
    always_comb
    begin
        if (ctrl.hit)
        begin
            shift = !seen_in;
        end
        else
        begin
            shift = ctrl.fill;
        end
        entry_next = (ctrl.accept && shift) ? left_page : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
